FILE: sv/ssbc_pkg.sv
// Shared constants, codes and types for the stepper step and button control block.
package ssbc_pkg;

    localparam int PERIOD_BITS   = 17;
    localparam int DEBOUNCE_BITS = 20;
    localparam int LEVEL_BITS    = 8;
    localparam int PULSE_BITS    = 8;
    localparam int FUNC_BITS     = 3;
    localparam int STATUS_BITS   = 2;

    localparam int CFG_DATA_BITS = (DEBOUNCE_BITS > PERIOD_BITS) ?
                                   ((DEBOUNCE_BITS > PULSE_BITS) ? DEBOUNCE_BITS : PULSE_BITS) :
                                   ((PERIOD_BITS > PULSE_BITS) ? PERIOD_BITS : PULSE_BITS);

    // Speed map: q = floor(level * diff / 100) via reciprocal multiply.
    localparam int PCT_DIV      = 100;
    localparam int PCT_LOG2     = 7;
    localparam int PROD_BITS    = LEVEL_BITS + PERIOD_BITS;
    localparam int RECIP_SHIFT  = PROD_BITS + PCT_LOG2;
    localparam int RECIP_BITS   = PROD_BITS + 1;
    localparam longint unsigned RECIP_L =
        ((64'd1 << RECIP_SHIFT) + 64'(PCT_DIV) - 64'd1) / 64'(PCT_DIV);
    localparam logic [RECIP_BITS-1:0] RECIP = RECIP_BITS'(RECIP_L);
    localparam int QUOT_BITS    = PROD_BITS + RECIP_BITS - RECIP_SHIFT;

    localparam logic [LEVEL_BITS-1:0]    MAX_LEVEL       = LEVEL_BITS'(100);
    localparam logic [DEBOUNCE_BITS-1:0] DEBOUNCE_RESET  = DEBOUNCE_BITS'(50000);
    localparam logic [PERIOD_BITS-1:0]   SLOW_RESET      = PERIOD_BITS'(100000);
    localparam logic [PERIOD_BITS-1:0]   FAST_RESET      = PERIOD_BITS'(260);
    localparam logic [PERIOD_BITS-1:0]   PERIOD_RESET    = PERIOD_BITS'(260);
    localparam logic [PULSE_BITS-1:0]    PULSE_RESET     = PULSE_BITS'(2);

    typedef enum logic [FUNC_BITS-1:0] {
        FN_TICK      = 3'd0,
        FN_SET_SPEED = 3'd1,
        FN_RUN_FWD   = 3'd2,
        FN_RUN_REV   = 3'd3,
        FN_STOP      = 3'd4,
        FN_STOP_ALL  = 3'd5,
        FN_UNKNOWN   = 3'd6
    } t_func;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK      = 2'd0,
        ST_DUP     = 2'd1,
        ST_RANGE   = 2'd2,
        ST_UNKNOWN = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CFG_DEBOUNCE = 2'd0,
        CFG_SLOW     = 2'd1,
        CFG_FAST     = 2'd2,
        CFG_PULSE    = 2'd3
    } t_cfg_idx;

endpackage

FILE: sv/ssbc_debounce.sv
// Button debouncer with press-and-release qualification for one button.
module ssbc_debounce (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_raw,
    input  logic [ssbc_pkg::DEBOUNCE_BITS-1:0] i_ticks,
    output logic                              o_fire
);
    import ssbc_pkg::*;

    localparam logic [DEBOUNCE_BITS-1:0] DebMax = '1;

    logic                     r_last, n_last;
    logic                     r_stable, n_stable;
    logic [DEBOUNCE_BITS-1:0] r_settle, n_settle;
    logic [DEBOUNCE_BITS-1:0] r_press, n_press;

    always_comb begin
        n_last   = i_raw;
        n_stable = r_stable;
        o_fire   = 1'b0;
        if (i_raw != r_last) begin
            n_settle = '0;
        end else if (r_settle != DebMax) begin
            n_settle = r_settle + DEBOUNCE_BITS'(1);
        end else begin
            n_settle = r_settle;
        end
        n_press = (r_press != DebMax) ? r_press + DEBOUNCE_BITS'(1) : r_press;
        if (n_settle > i_ticks && i_raw != r_stable) begin
            n_stable = i_raw;
            if (!i_raw) begin
                n_press = '0;
            end else if (n_press > i_ticks) begin
                o_fire = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last   <= 1'b1;
            r_stable <= 1'b1;
            r_settle <= '0;
            r_press  <= '0;
        end else if (i_en) begin
            r_last   <= n_last;
            r_stable <= n_stable;
            r_settle <= n_settle;
            r_press  <= n_press;
        end
    end

endmodule

FILE: sv/stepper_step_and_button_control.sv
// Stepper step pulse generator with debounced start and reverse buttons.
// Each accepted item is one time tick; the block takes one item every clock cycle while
// o_stall is low, and each item first passes through the input register and the speed
// map: one stage multiplies the level by the period span, a second multiplies by the
// reciprocal of 100, and the third applies the command, button and pulse logic to the
// motor state and loads the result register. A stalled result holds the pipeline only
// once no empty stage remains ahead of it, so the input stalls after that point.
module stepper_step_and_button_control (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration write
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [1:0]                         i_cfg_index,
    input  logic [ssbc_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    // input items
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [ssbc_pkg::FUNC_BITS-1:0]     i_func,
    input  logic [ssbc_pkg::LEVEL_BITS-1:0]    i_speed_level,
    input  logic                               i_start_button,
    input  logic                               i_reverse_button,
    // result items
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic                               o_step_out,
    output logic                               o_enable_n,
    output logic                               o_dir_out,
    output logic                               o_running,
    output logic [ssbc_pkg::STATUS_BITS-1:0]   o_cmd_status
);
    import ssbc_pkg::*;

    localparam logic [PERIOD_BITS-1:0] PeriodMax = '1;

    // configuration
    logic [DEBOUNCE_BITS-1:0] r_deb_ticks;
    logic [PERIOD_BITS-1:0]   r_slow;
    logic [PERIOD_BITS-1:0]   r_fast;
    logic [PULSE_BITS-1:0]    r_pulse;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deb_ticks <= DEBOUNCE_RESET;
            r_slow      <= SLOW_RESET;
            r_fast      <= FAST_RESET;
            r_pulse     <= PULSE_RESET;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_DEBOUNCE: r_deb_ticks <= i_cfg_data[DEBOUNCE_BITS-1:0];
                CFG_SLOW:     r_slow      <= i_cfg_data[PERIOD_BITS-1:0];
                CFG_FAST:     r_fast      <= i_cfg_data[PERIOD_BITS-1:0];
                CFG_PULSE:    r_pulse     <= i_cfg_data[PULSE_BITS-1:0];
                default: ;
            endcase
        end
    end

    logic                   fast_ge;
    logic [PERIOD_BITS-1:0] span;

    assign fast_ge = (r_fast >= r_slow);
    assign span    = fast_ge ? (r_fast - r_slow) : (r_slow - r_fast);

    // pipeline flow control
    logic r_s1_valid, r_s2_valid, r_s3_valid, r_out_valid;
    logic rdy_out, rdy3, rdy2, rdy1, take;

    assign rdy_out = !r_out_valid || !i_stall;
    assign rdy3    = !r_s3_valid || rdy_out;
    assign rdy2    = !r_s2_valid || rdy3;
    assign rdy1    = !r_s1_valid || rdy2;
    assign take    = r_s3_valid && rdy_out;
    assign o_stall = !rdy1;
    assign o_valid = r_out_valid;

    // stage payloads
    logic [FUNC_BITS-1:0]  r_s1_func, r_s2_func, r_s3_func;
    logic [LEVEL_BITS-1:0] r_s1_lvl, r_s2_lvl, r_s3_lvl;
    logic                  r_s1_sb, r_s2_sb, r_s3_sb;
    logic                  r_s1_rb, r_s2_rb, r_s3_rb;
    logic [PROD_BITS-1:0]  r_s2_prod;
    logic [QUOT_BITS-1:0]  r_s3_quot;

    logic [PROD_BITS+RECIP_BITS-1:0] recip_prod;

    assign recip_prod = PROD_BITS'(r_s2_prod) * RECIP;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            if (rdy1) r_s1_valid <= i_valid;
            if (rdy2) r_s2_valid <= r_s1_valid;
            if (rdy3) r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_s1_func <= i_func;
            r_s1_lvl  <= i_speed_level;
            r_s1_sb   <= i_start_button;
            r_s1_rb   <= i_reverse_button;
        end
        if (rdy2) begin
            r_s2_func <= r_s1_func;
            r_s2_lvl  <= r_s1_lvl;
            r_s2_sb   <= r_s1_sb;
            r_s2_rb   <= r_s1_rb;
            r_s2_prod <= r_s1_lvl * span;
        end
        if (rdy3) begin
            r_s3_func <= r_s2_func;
            r_s3_lvl  <= r_s2_lvl;
            r_s3_sb   <= r_s2_sb;
            r_s3_rb   <= r_s2_rb;
            r_s3_quot <= recip_prod[PROD_BITS+RECIP_BITS-1:RECIP_SHIFT];
        end
    end

    // button debouncers, advanced once per item
    logic start_fire, rev_fire;

    ssbc_debounce u_start_deb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (take),
        .i_raw   (r_s3_sb),
        .i_ticks (r_deb_ticks),
        .o_fire  (start_fire)
    );

    ssbc_debounce u_rev_deb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (take),
        .i_raw   (r_s3_rb),
        .i_ticks (r_deb_ticks),
        .o_fire  (rev_fire)
    );

    // motor state
    logic                   r_run, n_run;
    logic                   r_dir, n_dir;
    logic [PERIOD_BITS-1:0] r_period, n_period;
    logic [PERIOD_BITS-1:0] r_since, n_since;
    logic [PULSE_BITS-1:0]  r_pleft, n_pleft;
    logic [FUNC_BITS-1:0]   r_lcode, n_lcode;
    logic [LEVEL_BITS-1:0]  r_llvl, n_llvl;
    t_status                status;
    logic                   step;
    logic                   dup;
    logic [QUOT_BITS-1:0]   mapped;

    assign mapped = fast_ge ? (QUOT_BITS'(r_slow) + r_s3_quot)
                            : (QUOT_BITS'(r_slow) - r_s3_quot);
    assign dup = (r_s3_func == r_lcode) &&
                 (r_s3_func != FN_SET_SPEED || r_s3_lvl == r_llvl);

    always_comb begin
        n_run    = r_run;
        n_dir    = r_dir;
        n_period = r_period;
        n_lcode  = r_lcode;
        n_llvl   = r_llvl;
        n_pleft  = r_pleft;
        status   = ST_OK;

        case (t_func'(r_s3_func))
            FN_TICK: ;
            FN_STOP_ALL: begin
                n_run   = 1'b0;
                n_pleft = '0;
            end
            FN_SET_SPEED, FN_RUN_FWD, FN_RUN_REV, FN_STOP: begin
                if (dup) begin
                    status = ST_DUP;
                end else begin
                    n_lcode = r_s3_func;
                    n_llvl  = r_s3_lvl;
                    case (t_func'(r_s3_func))
                        FN_SET_SPEED: begin
                            if (r_s3_lvl > MAX_LEVEL) begin
                                status = ST_RANGE;
                            end else begin
                                n_period = mapped[PERIOD_BITS-1:0];
                                n_run    = 1'b1;
                            end
                        end
                        FN_RUN_FWD: begin
                            n_run = 1'b1;
                            n_dir = 1'b1;
                        end
                        FN_RUN_REV: begin
                            n_run = 1'b1;
                            n_dir = 1'b0;
                        end
                        default: begin
                            n_run = 1'b0;
                            n_dir = 1'b1;
                        end
                    endcase
                end
            end
            default: begin
                n_lcode = FN_UNKNOWN;
                status  = ST_UNKNOWN;
            end
        endcase

        n_run = n_run ^ start_fire;
        n_dir = n_dir ^ rev_fire;

        n_since = (r_since != PeriodMax) ? r_since + PERIOD_BITS'(1) : r_since;
        if (!n_run) begin
            n_pleft = '0;
        end else if (n_pleft == '0 && n_since >= n_period) begin
            // zero width counts as one tick
            n_pleft = (r_pulse != '0) ? r_pulse : PULSE_BITS'(1);
            n_since = '0;
        end
        step = (n_pleft != '0);
        if (step) begin
            n_pleft = n_pleft - PULSE_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run    <= 1'b0;
            r_dir    <= 1'b1;
            r_period <= PERIOD_RESET;
            r_since  <= '0;
            r_pleft  <= '0;
            r_lcode  <= FN_TICK;
            r_llvl   <= '0;
        end else if (take) begin
            r_run    <= n_run;
            r_dir    <= n_dir;
            r_period <= n_period;
            r_since  <= n_since;
            r_pleft  <= n_pleft;
            r_lcode  <= n_lcode;
            r_llvl   <= n_llvl;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (rdy_out) begin
            r_out_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            o_step_out   <= step;
            o_enable_n   <= !n_run;
            o_dir_out    <= n_dir;
            o_running    <= n_run;
            o_cmd_status <= status;
        end
    end

endmodule

FILE: dv/tb_stepper_step_and_button_control.sv
// Testbench for the stepper step and button control block: directed and random ticks.
`timescale 1ns / 1ps

module tb_stepper_step_and_button_control;
    import ssbc_pkg::*;

    localparam int          WATCHDOG_LIMIT = 1000;
    localparam int unsigned PERIOD_MAX     = (1 << PERIOD_BITS) - 1;
    localparam int unsigned DEB_MAX        = (1 << DEBOUNCE_BITS) - 1;
    // Top encoding of func; decodes as unknown like FN_UNKNOWN.
    localparam logic [FUNC_BITS-1:0] FN_UNKNOWN_HI = 3'd7;

    typedef struct packed {
        logic    step;
        logic    enable_n;
        logic    dir;
        logic    run;
        t_status status;
    } t_motor_out;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [1:0]               i_cfg_index = CFG_DEBOUNCE;
    logic [CFG_DATA_BITS-1:0] i_cfg_data = '0;
    logic                     i_valid = 1'b0;
    logic                     o_stall;
    logic [FUNC_BITS-1:0]     i_func = FN_TICK;
    logic [LEVEL_BITS-1:0]    i_speed_level = '0;
    logic                     i_start_button = 1'b1;
    logic                     i_reverse_button = 1'b1;
    logic                     o_valid;
    logic                     i_stall = 1'b0;
    logic                     o_step_out;
    logic                     o_enable_n;
    logic                     o_dir_out;
    logic                     o_running;
    logic [STATUS_BITS-1:0]   o_cmd_status;

    stepper_step_and_button_control i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_func          (i_func),
        .i_speed_level   (i_speed_level),
        .i_start_button  (i_start_button),
        .i_reverse_button(i_reverse_button),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_step_out      (o_step_out),
        .o_enable_n      (o_enable_n),
        .o_dir_out       (o_dir_out),
        .o_running       (o_running),
        .o_cmd_status    (o_cmd_status)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // Motor model state and its copy of the registers
    logic [DEBOUNCE_BITS-1:0] deb_ticks;
    logic [PERIOD_BITS-1:0]   slow_per, fast_per;
    logic [PULSE_BITS-1:0]    pulse_width;
    logic                     motor_run, motor_dir;
    logic [PERIOD_BITS-1:0]   step_per, ticks_since_step;
    logic [PULSE_BITS-1:0]    pulse_remaining;
    logic [FUNC_BITS-1:0]     last_cmd;
    logic [LEVEL_BITS-1:0]    last_level;
    logic                     btn_raw[2], btn_stable[2];
    logic [DEBOUNCE_BITS-1:0] btn_settle[2], btn_held[2];

    t_motor_out pending_motor_q[$];

    int  error_count = 0;
    int  ticks_sent = 0;
    int  results_seen = 0;
    int  settings_applied = 0;
    int  pulse_ticks_seen = 0;
    int  dup_seen = 0;
    int  range_seen = 0;
    int  unknown_seen = 0;
    int  idle_cycles = 0;
    bit  no_gaps = 1'b0;

    // Random button stimulus: current level and ticks left at that level
    logic                 stim_btn[2] = '{1'b1, 1'b1};
    int                   stim_hold[2] = '{0, 0};
    logic [FUNC_BITS-1:0] prev_cmd = FN_SET_SPEED;
    logic [LEVEL_BITS-1:0] prev_level = '0;

    function automatic void motor_reset();
        deb_ticks       = DEBOUNCE_RESET;
        slow_per        = SLOW_RESET;
        fast_per        = FAST_RESET;
        pulse_width     = PULSE_RESET;
        motor_run       = 1'b0;
        motor_dir       = 1'b1;
        step_per        = PERIOD_RESET;
        ticks_since_step = '0;
        pulse_remaining = '0;
        last_cmd        = FN_TICK;
        last_level      = '0;
        for (int b = 0; b < 2; b++) begin
            btn_raw[b]    = 1'b1;
            btn_stable[b] = 1'b1;
            btn_settle[b] = '0;
            btn_held[b]   = '0;
        end
    endfunction

    // Linear map, truncating toward the slow period
    function automatic logic [PERIOD_BITS-1:0] level_to_period(logic [LEVEL_BITS-1:0] lvl);
        longint unsigned s, f, l;
        s = slow_per;
        f = fast_per;
        l = lvl;
        if (f >= s) begin
            return PERIOD_BITS'(s + (l * (f - s)) / PCT_DIV);
        end
        return PERIOD_BITS'(s - (l * (s - f)) / PCT_DIV);
    endfunction

    // Returns 1 when a qualified press-and-release completes
    function automatic bit button_released(int b, logic raw);
        bit fire;
        fire = 1'b0;
        if (raw != btn_raw[b]) begin
            btn_settle[b] = '0;
        end else if (btn_settle[b] != '1) begin
            btn_settle[b]++;
        end
        if (btn_held[b] != '1) begin
            btn_held[b]++;
        end
        if (btn_settle[b] > deb_ticks && raw != btn_stable[b]) begin
            btn_stable[b] = raw;
            if (!raw) begin
                btn_held[b] = '0;
            end else if (btn_held[b] > deb_ticks) begin
                fire = 1'b1;
            end
        end
        btn_raw[b] = raw;
        return fire;
    endfunction

    function automatic t_motor_out motor_tick(logic [FUNC_BITS-1:0] fn,
                                              logic [LEVEL_BITS-1:0] lvl,
                                              logic sb, logic rb);
        t_motor_out res;
        t_status    st;
        st = ST_OK;
        if (fn == FN_STOP_ALL) begin
            motor_run       = 1'b0;
            pulse_remaining = '0;
        end else if (fn >= FN_UNKNOWN) begin
            last_cmd = FN_UNKNOWN;
            st       = ST_UNKNOWN;
        end else if (fn != FN_TICK) begin
            if (fn == last_cmd && (fn != FN_SET_SPEED || lvl == last_level)) begin
                st = ST_DUP;
            end else begin
                last_cmd   = fn;
                last_level = lvl;
                case (fn)
                    FN_SET_SPEED: begin
                        if (lvl > MAX_LEVEL) begin
                            st = ST_RANGE;
                        end else begin
                            step_per  = level_to_period(lvl);
                            motor_run = 1'b1;
                        end
                    end
                    FN_RUN_FWD: begin
                        motor_run = 1'b1;
                        motor_dir = 1'b1;
                    end
                    FN_RUN_REV: begin
                        motor_run = 1'b1;
                        motor_dir = 1'b0;
                    end
                    default: begin
                        motor_run = 1'b0;
                        motor_dir = 1'b1;
                    end
                endcase
            end
        end

        if (button_released(0, sb)) motor_run = ~motor_run;
        if (button_released(1, rb)) motor_dir = ~motor_dir;

        if (ticks_since_step != '1) ticks_since_step++;
        if (!motor_run) begin
            pulse_remaining = '0;
        end else if (pulse_remaining == '0 && ticks_since_step >= step_per) begin
            pulse_remaining  = (pulse_width != '0) ? pulse_width : PULSE_BITS'(1);
            ticks_since_step = '0;
        end

        res.step = (pulse_remaining != '0);
        if (pulse_remaining != '0) pulse_remaining--;
        res.enable_n = ~motor_run;
        res.dir      = motor_dir;
        res.run      = motor_run;
        res.status   = st;
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("[%0t] result %0d: %s got %0d want %0d", $realtime, results_seen, what,
                 got, want);
        error_count++;
    endtask

    task automatic send_tick(logic [FUNC_BITS-1:0] fn, logic [LEVEL_BITS-1:0] lvl,
                             logic sb, logic rb);
        while (!no_gaps && $urandom_range(99) < 9) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_func           <= fn;
        i_speed_level    <= lvl;
        i_start_button   <= sb;
        i_reverse_button <= rb;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_motor_q.push_back(motor_tick(fn, lvl, sb, rb));
        ticks_sent++;
    endtask

    // Wait until every pending result is out, with the input idle
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_motor_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic apply_settings(int unsigned deb, int unsigned slow, int unsigned fast,
                                  int unsigned pulse);
        int unsigned vals[4];
        vals = '{deb, slow, fast, pulse};
        for (int k = 0; k < 4; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= t_cfg_idx'(k);
            i_cfg_data  <= CFG_DATA_BITS'(vals[k]);
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            case (t_cfg_idx'(k))
                CFG_DEBOUNCE: deb_ticks   = DEBOUNCE_BITS'(vals[k]);
                CFG_SLOW:     slow_per    = PERIOD_BITS'(vals[k]);
                CFG_FAST:     fast_per    = PERIOD_BITS'(vals[k]);
                default:      pulse_width = PULSE_BITS'(vals[k]);
            endcase
        end
        i_cfg_valid <= 1'b0;
        settings_applied++;
    endtask

    task automatic test_reset_state();
        send_tick(FN_TICK, '0, 1'b1, 1'b1);
        send_tick(FN_SET_SPEED, 8'd50, 1'b1, 1'b1);
        send_tick(FN_RUN_FWD, '1, 1'b1, 1'b1);
    endtask

    task automatic test_commands();
        send_tick(FN_TICK, '0, 1'b1, 1'b1);
        send_tick(FN_SET_SPEED, 8'd0, 1'b1, 1'b1);
        send_tick(FN_SET_SPEED, 8'd0, 1'b1, 1'b1);
        send_tick(FN_SET_SPEED, MAX_LEVEL, 1'b1, 1'b1);
        send_tick(FN_SET_SPEED, MAX_LEVEL + 8'd1, 1'b1, 1'b1);
        send_tick(FN_SET_SPEED, '1, 1'b1, 1'b1);
        send_tick(FN_SET_SPEED, '1, 1'b1, 1'b1);
        send_tick(FN_RUN_REV, 8'hAA, 1'b1, 1'b1);
        send_tick(FN_RUN_REV, 8'h55, 1'b1, 1'b1);
        send_tick(FN_RUN_FWD, '0, 1'b1, 1'b1);
        send_tick(FN_STOP, '0, 1'b1, 1'b1);
        send_tick(FN_STOP, '0, 1'b1, 1'b1);
        send_tick(FN_UNKNOWN, '0, 1'b1, 1'b1);
        send_tick(FN_UNKNOWN_HI, '1, 1'b1, 1'b1);
        send_tick(FN_STOP, '0, 1'b1, 1'b1);
        send_tick(FN_STOP_ALL, '0, 1'b1, 1'b1);
    endtask

    // Both buttons pressed and released long enough to qualify
    task automatic test_buttons();
        repeat (3) send_tick(FN_TICK, '0, 1'b0, 1'b0);
        repeat (5) send_tick(FN_TICK, '0, 1'b1, 1'b1);
    endtask

    task automatic run_random_ticks(int count);
        int unsigned          pick;
        logic [FUNC_BITS-1:0] fn;
        logic [LEVEL_BITS-1:0] lvl;
        for (int i = 0; i < count; i++) begin
            for (int b = 0; b < 2; b++) begin
                if (stim_hold[b] == 0) begin
                    stim_btn[b] = ~stim_btn[b];
                    if ($urandom_range(9) < 2) begin
                        stim_hold[b] = $urandom_range(1, 3);   // contact bounce
                    end else if (deb_ticks < 12) begin
                        stim_hold[b] = int'(deb_ticks) + $urandom_range(2, 6);
                    end else begin
                        stim_hold[b] = $urandom_range(4, 30);
                    end
                end
                stim_hold[b]--;
            end
            pick = $urandom_range(99);
            lvl  = ($urandom_range(3) == 0) ? LEVEL_BITS'($urandom_range(255))
                                            : LEVEL_BITS'($urandom_range(100));
            if (pick < 55) begin
                fn = FN_TICK;
            end else if (pick < 70) begin
                fn  = prev_cmd;
                lvl = prev_level;
            end else begin
                fn = FUNC_BITS'($urandom_range(int'(FN_UNKNOWN), int'(FN_SET_SPEED)));
            end
            if (fn != FN_TICK) begin
                prev_cmd   = fn;
                prev_level = lvl;
            end
            send_tick(fn, lvl, stim_btn[0], stim_btn[1]);
        end
    endtask

    task automatic test_random_traffic();
        int unsigned deb_set[6];
        int unsigned slow_set[6];
        int unsigned fast_set[6];
        int unsigned pulse_set[6];
        deb_set   = '{0, 3, DEB_MAX, 2, 4, 1};
        slow_set  = '{12, 5, 30, 1, PERIOD_MAX, 9};
        fast_set  = '{1, 40, 2, 1, 7, PERIOD_MAX};
        pulse_set = '{1, 3, 255, 0, 5, 4};
        for (int p = 0; p < 6; p++) begin
            wait_drained();
            apply_settings(deb_set[p], slow_set[p], fast_set[p], pulse_set[p]);
            no_gaps = (p == 1);
            run_random_ticks(88);
        end
        no_gaps = 1'b0;
    endtask

    always @(posedge i_clk) begin
        i_stall <= !no_gaps && ($urandom_range(99) < 9);
    end

    always @(posedge i_clk) begin : check_results
        t_motor_out want;
        if (i_rst_n && o_valid === 1'b1 && i_stall == 1'b0) begin
            results_seen++;
            if (pending_motor_q.size() == 0) begin
                report_mismatch("result with nothing pending", 1, 0);
            end else begin
                want = pending_motor_q.pop_front();
                if (o_step_out !== want.step)
                    report_mismatch("step_out", o_step_out, want.step);
                if (o_enable_n !== want.enable_n)
                    report_mismatch("enable_n", o_enable_n, want.enable_n);
                if (o_dir_out !== want.dir)
                    report_mismatch("dir_out", o_dir_out, want.dir);
                if (o_running !== want.run)
                    report_mismatch("running", o_running, want.run);
                if (o_cmd_status !== want.status)
                    report_mismatch("cmd_status", o_cmd_status, want.status);
                if (want.step) pulse_ticks_seen++;
                if (want.status == ST_DUP) dup_seen++;
                if (want.status == ST_RANGE) range_seen++;
                if (want.status == ST_UNKNOWN) unknown_seen++;
            end
        end
    end

    // Ends the run when no handshake of any kind completes for too long
    always @(posedge i_clk) begin
        if ((i_valid === 1'b1 && o_stall === 1'b0) || (o_valid === 1'b1 && i_stall === 1'b0) ||
            (i_cfg_valid === 1'b1 && o_cfg_ready === 1'b1)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        motor_reset();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        wait_drained();
        apply_settings(1, 20, 3, 2);
        test_commands();
        test_buttons();
        test_random_traffic();
        wait_drained();

        $display("%0d ticks over %0d register settings, %0d results checked",
                 ticks_sent, settings_applied, results_seen);
        $display("%0d step pulse ticks, %0d duplicates, %0d range errors, %0d unknown commands",
                 pulse_ticks_seen, dup_seen, range_seen, unknown_seen);
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

FILE: sim.f
sv/ssbc_pkg.sv
sv/ssbc_debounce.sv
sv/stepper_step_and_button_control.sv
dv/tb_stepper_step_and_button_control.sv
